// File: hdl/mpgs_pkg.sv
// Package with the shared constants, types and helper function of the gate sequencer.
`timescale 1ns / 1ps

package mpgs_pkg;

    // Counter width for the clock period, the sample counter and the gate length.
    localparam int COUNT_BITS   = 24;
    // Gate length in samples used before any clock period has been measured.
    localparam int DEFAULT_GATE = 48;

    localparam int PATTERN_BITS = 16;
    localparam int MULT_BITS    = 5;
    localparam int STEPS_BITS   = 5;
    localparam int WIDTH_BITS   = 9;
    localparam int STEP_BITS    = 4;
    localparam int MODE_BITS    = 2;

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 16;

    typedef logic [COUNT_BITS-1:0]   count_t;
    typedef logic [PATTERN_BITS-1:0] pattern_t;
    typedef logic [STEP_BITS-1:0]    step_t;

    localparam longint unsigned CNT_MAX_L = (64'd1 << COUNT_BITS) - 64'd1;
    localparam count_t CNT_MAX = COUNT_BITS'(CNT_MAX_L);
    localparam count_t DEFAULT_LEN =
        COUNT_BITS'((64'(DEFAULT_GATE) > CNT_MAX_L) ? CNT_MAX_L : 64'(DEFAULT_GATE));

    // Register indexes on the configuration channel.
    localparam logic [CFG_INDEX_BITS-1:0] REG_BASE_PATTERN = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MASK_MODE    = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MULTIPLIER   = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_STEP_COUNT   = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_GATE_WIDTH   = 3'd4;

    // Mask selection codes.
    localparam logic [MODE_BITS-1:0] MASK_NONE = 2'd0;
    localparam logic [MODE_BITS-1:0] MASK_A    = 2'd1;
    localparam logic [MODE_BITS-1:0] MASK_B    = 2'd2;
    localparam logic [MODE_BITS-1:0] MASK_C    = 2'd3;

    localparam pattern_t MASK_A_WORD = 16'h0F0F;
    localparam pattern_t MASK_B_WORD = 16'hF003;
    localparam pattern_t MASK_C_WORD = 16'h01F0;

    localparam logic [MULT_BITS-1:0]  MULT_MAX   = 5'd16;
    localparam logic [STEPS_BITS-1:0] STEPS_MAX  = 5'd16;
    localparam logic [WIDTH_BITS-1:0] WIDTH_FULL = 9'd256;

    // Remainder of a value up to 16 by a length of 1 to 16, by five
    // shifted compare-and-subtract steps.
    function automatic step_t step_wrap(input logic [STEPS_BITS-1:0] value,
                                        input logic [STEPS_BITS-1:0] len);
        logic [STEPS_BITS+STEP_BITS-1:0] rem;
        logic [STEPS_BITS+STEP_BITS-1:0] sub;
        rem = {{STEP_BITS{1'b0}}, value};
        for (int k = STEP_BITS; k >= 0; k--)
        begin
            sub = {{STEP_BITS{1'b0}}, len} << k;
            if (rem >= sub)
            begin
                rem = rem - sub;
            end
        end
        return rem[STEP_BITS-1:0];
    endfunction

endpackage

// File: hdl/mpgs_if.sv
// Channel interfaces for samples, gate results and configuration writes.
`timescale 1ns / 1ps

interface mpgs_sample_if;
    logic valid;
    logic ready;
    logic clock_high;
    logic reset_high;
    modport source (output valid, clock_high, reset_high, input ready);
    modport sink   (input valid, clock_high, reset_high, output ready);
endinterface

interface mpgs_gate_if;
    logic valid;
    logic ready;
    logic gate_out;
    modport source (output valid, gate_out, input ready);
    modport sink   (input valid, gate_out, output ready);
endinterface

interface mpgs_cfg_if;
    import mpgs_pkg::*;
    logic                      valid;
    logic                      ready;
    logic [CFG_INDEX_BITS-1:0] index;
    logic [CFG_DATA_BITS-1:0]  data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: hdl/masked_pattern_gate_sequencer.sv
// Top level of the masked pattern gate sequencer: sample channel in, gate channel out.
`timescale 1ns / 1ps

// Each word on the samples channel is one audio sample carrying the levels of
// a clock input and a reset input. For each sample the block returns exactly
// one word on the gates channel holding the gate level for that sample.
// The cfg channel writes the five registers (base pattern, mask mode,
// multiplier, step count, gate width); it is always ready and must only be
// used while no sample is in flight.
//
// A sample is taken into an input register, processed by combinational logic
// (edge detection, the pattern multiply, the gate length multiply and the
// counter updates) and written into the output register. The gate word is
// valid once the output register holds it. One sample is accepted every
// cycle while the receiver does not stall, since all the work for a sample
// is a single pass of logic.
//
// When the receiver stalls, the output register holds its word and the input
// register holds the next sample; the samples channel drops ready only when
// both are full. Reset clears both registers, the sequencer state and the
// configuration registers to their defaults (step count 16, width one half).

module masked_pattern_gate_sequencer (
    input  logic                 clk,
    input  logic                 rst_n,
    mpgs_sample_if.sink          samples,
    mpgs_gate_if.source          gates,
    mpgs_cfg_if.sink             cfg
);
    import mpgs_pkg::*;

    localparam int PROD_BITS = WIDTH_BITS + COUNT_BITS;
    localparam int GLEN_BITS = PROD_BITS - 8;

    // Configuration registers.
    pattern_t                base_pattern_reg;
    logic [MODE_BITS-1:0]    mask_mode_reg;
    logic [MULT_BITS-1:0]    multiplier_reg;
    logic [STEPS_BITS-1:0]   step_count_reg;
    logic [WIDTH_BITS-1:0]   gate_width_reg;

    // Input and output registers.
    logic in_valid_reg;
    logic clock_smp_reg;
    logic reset_smp_reg;
    logic out_valid_reg;
    logic gate_reg;

    // Sequencer state.
    logic   clock_prev_reg, clock_prev_next;
    logic   reset_prev_reg, reset_prev_next;
    step_t  step_reg, step_next;
    count_t since_reg, since_next;
    count_t period_reg, period_next;
    count_t gate_left_reg, gate_left_next;
    logic   gate_next;

    logic process;

    // A sample is processed when the output register is free or is being emptied.
    assign process       = in_valid_reg && (!out_valid_reg || gates.ready);
    assign samples.ready = !in_valid_reg || process;
    assign gates.valid   = out_valid_reg;
    assign gates.gate_out = gate_reg;
    assign cfg.ready     = 1'b1;

    // Pattern and gate length logic.
    pattern_t               masked;
    logic [MULT_BITS-1:0]   fac;
    logic [PATTERN_BITS+MULT_BITS-1:0] pat_prod;
    pattern_t               pattern;
    logic [STEPS_BITS-1:0]  len;
    logic [WIDTH_BITS-1:0]  width;
    logic                   clk_rise;
    logic                   rst_rise;
    step_t                  step_cur;
    count_t                 gate_left_cur;
    logic [PROD_BITS-1:0]   glen_prod;
    logic [GLEN_BITS-1:0]   glen_raw;
    count_t                 glen;

    always_comb
    begin
        unique case (mask_mode_reg)
            MASK_A:    masked = base_pattern_reg & MASK_A_WORD;
            MASK_B:    masked = base_pattern_reg & MASK_B_WORD;
            MASK_C:    masked = base_pattern_reg & MASK_C_WORD;
            default:   masked = base_pattern_reg;
        endcase
        fac      = (multiplier_reg > MULT_MAX) ? MULT_MAX : multiplier_reg;
        pat_prod = {{MULT_BITS{1'b0}}, masked} * {{PATTERN_BITS{1'b0}}, fac};
        // Fold the product's upper bits back onto its low sixteen bits.
        pattern  = pat_prod[PATTERN_BITS-1:0]
                 | {{(PATTERN_BITS-MULT_BITS){1'b0}}, pat_prod[PATTERN_BITS+MULT_BITS-1:PATTERN_BITS]};
    end

    always_comb
    begin
        if (step_count_reg == '0)
        begin
            len = STEPS_BITS'(1);
        end
        else if (step_count_reg > STEPS_MAX)
        begin
            len = STEPS_MAX;
        end
        else
        begin
            len = step_count_reg;
        end
        width = (gate_width_reg > WIDTH_FULL) ? WIDTH_FULL : gate_width_reg;
    end

    always_comb
    begin
        clk_rise = clock_smp_reg && !clock_prev_reg;
        rst_rise = reset_smp_reg && !reset_prev_reg;

        clock_prev_next = clock_smp_reg;
        reset_prev_next = reset_smp_reg;

        // Reset edge acts first, so a clock edge in the same sample sees step zero.
        step_cur      = rst_rise ? '0 : step_reg;
        gate_left_cur = rst_rise ? '0 : gate_left_reg;

        // A clock edge with no samples counted keeps the previous period.
        if (clk_rise && (since_reg != '0))
        begin
            period_next = since_reg;
        end
        else
        begin
            period_next = period_reg;
        end

        glen_prod = {{COUNT_BITS{1'b0}}, width} * {{WIDTH_BITS{1'b0}}, period_next};
        glen_raw  = glen_prod[PROD_BITS-1:8];
        if (period_next == '0)
        begin
            glen = DEFAULT_LEN;
        end
        else if (glen_raw > {{(GLEN_BITS-COUNT_BITS){1'b0}}, CNT_MAX})
        begin
            glen = CNT_MAX;
        end
        else if (glen_raw == '0)
        begin
            glen = COUNT_BITS'(1);
        end
        else
        begin
            glen = glen_raw[COUNT_BITS-1:0];
        end

        step_next = step_cur;
        if (clk_rise)
        begin
            if (pattern[4'd15 - step_cur])
            begin
                gate_left_cur = glen;
            end
            step_next = step_wrap({1'b0, step_cur} + STEPS_BITS'(1), len);
        end

        if (clk_rise)
        begin
            since_next = COUNT_BITS'(1);
        end
        else if (since_reg != CNT_MAX)
        begin
            since_next = since_reg + COUNT_BITS'(1);
        end
        else
        begin
            since_next = since_reg;
        end

        gate_next      = (gate_left_cur != '0);
        gate_left_next = gate_next ? gate_left_cur - COUNT_BITS'(1) : gate_left_cur;
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_pattern_reg <= '0;
            mask_mode_reg    <= MASK_NONE;
            multiplier_reg   <= '0;
            step_count_reg   <= STEPS_MAX;
            gate_width_reg   <= WIDTH_BITS'(128);
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_BASE_PATTERN: base_pattern_reg <= cfg.data[PATTERN_BITS-1:0];
                REG_MASK_MODE:    mask_mode_reg    <= cfg.data[MODE_BITS-1:0];
                REG_MULTIPLIER:   multiplier_reg   <= cfg.data[MULT_BITS-1:0];
                REG_STEP_COUNT:   step_count_reg   <= cfg.data[STEPS_BITS-1:0];
                REG_GATE_WIDTH:   gate_width_reg   <= cfg.data[WIDTH_BITS-1:0];
                default:          ;
            endcase
        end
    end

    // Handshake control and sequencer state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            clock_prev_reg <= 1'b0;
            reset_prev_reg <= 1'b0;
            step_reg       <= '0;
            since_reg      <= '0;
            period_reg     <= '0;
            gate_left_reg  <= '0;
        end
        else
        begin
            if (samples.valid && samples.ready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (process)
            begin
                in_valid_reg <= 1'b0;
            end

            if (process)
            begin
                out_valid_reg  <= 1'b1;
                clock_prev_reg <= clock_prev_next;
                reset_prev_reg <= reset_prev_next;
                step_reg       <= step_next;
                since_reg      <= since_next;
                period_reg     <= period_next;
                gate_left_reg  <= gate_left_next;
            end
            else if (gates.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (samples.valid && samples.ready)
        begin
            clock_smp_reg <= samples.clock_high;
            reset_smp_reg <= samples.reset_high;
        end
        if (process)
        begin
            gate_reg <= gate_next;
        end
    end

endmodule
